@@ src/lfd_pkg.sv @@
// Package: shared types, codes and reset values of the link frame deframer.
`default_nettype none
package lfd_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] cfg_idx_t;

	// Configuration register indexes
	localparam cfg_idx_t CFG_SYNC_BYTE = 2'd0;
	localparam cfg_idx_t CFG_END_BYTE  = 2'd1;
	localparam cfg_idx_t CFG_SEQ_MSG   = 2'd2;

	// Configuration reset values
	localparam byte_t SYNC_BYTE_RST = 8'hFE;
	localparam byte_t END_BYTE_RST  = 8'hAA;
	localparam byte_t SEQ_MSG_RST   = 8'h05;

	// Frame status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_BAD_END   = 2'd1;
	localparam status_t ST_SEQ_GAP   = 2'd2;
	localparam status_t ST_LINK_LOST = 2'd3;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Input kinds
	localparam logic IN_BYTE      = 1'b0;
	localparam logic IN_LINK_LOST = 1'b1;

	// Last header field position (length, seq, sys, comp, msg)
	localparam byte_t HDR_LAST = 8'd4;

	typedef struct packed {
		logic    out_kind;
		byte_t   msg_id;
		byte_t   seq_num;
		byte_t   sys_id;
		byte_t   comp_id;
		byte_t   byte_index;
		byte_t   data_byte;
		byte_t   check_a;
		byte_t   check_b;
		status_t status;
	} result_t;

endpackage
`default_nettype wire

@@ src/lfd_if.sv @@
// Interfaces: byte input channel, result channel and configuration write channel.
`default_nettype none
interface lfd_in_if;
	logic           valid;
	logic           ready;
	logic           kind;
	lfd_pkg::byte_t rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface lfd_out_if;
	logic             valid;
	logic             ready;
	logic             out_kind;
	lfd_pkg::byte_t   msg_id;
	lfd_pkg::byte_t   seq_num;
	lfd_pkg::byte_t   sys_id;
	lfd_pkg::byte_t   comp_id;
	lfd_pkg::byte_t   byte_index;
	lfd_pkg::byte_t   data_byte;
	lfd_pkg::byte_t   check_a;
	lfd_pkg::byte_t   check_b;
	lfd_pkg::status_t status;

	modport source (output valid, output out_kind, output msg_id, output seq_num,
		output sys_id, output comp_id, output byte_index, output data_byte,
		output check_a, output check_b, output status, input ready);
	modport sink   (input valid, input out_kind, input msg_id, input seq_num,
		input sys_id, input comp_id, input byte_index, input data_byte,
		input check_a, input check_b, input status, output ready);
endinterface

interface lfd_cfg_if;
	logic              valid;
	logic              ready;
	lfd_pkg::cfg_idx_t index;
	lfd_pkg::byte_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/link_frame_deframer.sv @@
// Top level: byte-wise link frame parser with payload and frame status results.
//
//  channel | modport      | moves per transfer
//  --------+--------------+-------------------------------------------------
//  rx      | lfd_in_if    | one received byte or one link-lost event
//  result  | lfd_out_if   | one payload byte or one frame/link status
//  cfg     | lfd_cfg_if   | one register write (sync, end, sequenced id)
//
// One item per cycle sustained while results are taken. An accepted item is
// held in the input register, is parsed against the frame state and lands in
// the result register, from which it is offered on the result channel.
// Reset returns the parser to hunting and loads the register defaults.
// A result stalled on the output holds the input register, which stalls rx.
`default_nettype none
module link_frame_deframer
	import lfd_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	lfd_cfg_if.sink    cfg,
	lfd_in_if.sink     rx,
	lfd_out_if.source  result
);

	// Parser phase codes
	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_HEAD = 3'd1;
	localparam logic [2:0] PH_PAY  = 3'd2;
	localparam logic [2:0] PH_CHKA = 3'd3;
	localparam logic [2:0] PH_CHKB = 3'd4;
	localparam logic [2:0] PH_END  = 3'd5;

	// Configuration registers
	byte_t sync_q, end_q, seq_msg_q;

	// Input register
	logic  valid_s1;
	logic  kind_s1;
	byte_t byte_s1;

	// Frame state
	logic [2:0] phase_q, phase_d;
	byte_t      cnt_q, cnt_d;
	byte_t      len_q, len_d;
	byte_t      seq_q, seq_d;
	byte_t      sys_q, sys_d;
	byte_t      comp_q, comp_d;
	byte_t      msg_q, msg_d;
	byte_t      chka_q, chka_d;
	byte_t      chkb_q, chkb_d;
	byte_t      prev_q, prev_d;

	// Result register
	logic    out_valid_q;
	result_t res_q, res_d;
	logic    res_load;

	logic  out_free;
	logic  adv_s1;
	byte_t cnt_inc;

	assign out_free = !out_valid_q || result.ready;
	assign adv_s1   = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;
	assign cnt_inc  = cnt_q + 8'd1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= SYNC_BYTE_RST;
			end_q     <= END_BYTE_RST;
			seq_msg_q <= SEQ_MSG_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SYNC_BYTE: sync_q    <= cfg.data;
				CFG_END_BYTE:  end_q     <= cfg.data;
				CFG_SEQ_MSG:   seq_msg_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Capture input transfer, drop it once parsed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			kind_s1 <= rx.kind;
			byte_s1 <= rx.rx_byte;
		end
	end

	// Parse one item against the frame state
	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		seq_d    = seq_q;
		sys_d    = sys_q;
		comp_d   = comp_q;
		msg_d    = msg_q;
		chka_d   = chka_q;
		chkb_d   = chkb_q;
		prev_d   = prev_q;
		res_load = 1'b0;
		res_d    = '0;
		res_d.msg_id  = msg_q;
		res_d.seq_num = seq_q;
		res_d.sys_id  = sys_q;
		res_d.comp_id = comp_q;
		if (adv_s1) begin
			if (kind_s1 == IN_LINK_LOST) begin
				phase_d        = PH_HUNT;
				cnt_d          = '0;
				res_load       = 1'b1;
				res_d          = '0;
				res_d.out_kind = KIND_STATUS;
				res_d.status   = ST_LINK_LOST;
			end else begin
				unique case (phase_q)
					PH_HEAD: begin
						unique case (cnt_q)
							8'd0: len_d  = byte_s1;
							8'd1: seq_d  = byte_s1;
							8'd2: sys_d  = byte_s1;
							8'd3: comp_d = byte_s1;
							default: msg_d = byte_s1;
						endcase
						if (cnt_q >= HDR_LAST) begin
							cnt_d   = '0;
							phase_d = (len_q == 8'd0) ? PH_CHKA : PH_PAY;
						end else begin
							cnt_d = cnt_inc;
						end
					end
					PH_PAY: begin
						res_load         = 1'b1;
						res_d.out_kind   = KIND_PAYLOAD;
						res_d.byte_index = cnt_q;
						res_d.data_byte  = byte_s1;
						if (cnt_inc >= len_q) begin
							cnt_d   = '0;
							phase_d = PH_CHKA;
						end else begin
							cnt_d = cnt_inc;
						end
					end
					PH_CHKA: begin
						chka_d  = byte_s1;
						phase_d = PH_CHKB;
					end
					PH_CHKB: begin
						chkb_d  = byte_s1;
						phase_d = PH_END;
					end
					PH_END: begin
						res_load       = 1'b1;
						res_d.out_kind = KIND_STATUS;
						res_d.check_a  = chka_q;
						res_d.check_b  = chkb_q;
						if (byte_s1 != end_q) begin
							res_d.status = ST_BAD_END;
						end else begin
							res_d.status = ST_OK;
							if (msg_q == seq_msg_q) begin
								if (prev_q + 8'd1 != seq_q) res_d.status = ST_SEQ_GAP;
								prev_d = seq_q;
							end
						end
						phase_d = PH_HUNT;
						cnt_d   = '0;
					end
					default: begin
						// hunting, and any phase code without meaning
						if (byte_s1 == sync_q) begin
							phase_d = PH_HEAD;
							cnt_d   = '0;
						end else begin
							phase_d = PH_HUNT;
						end
					end
				endcase
			end
		end
	end

	// Advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			len_q   <= '0;
			seq_q   <= '0;
			sys_q   <= '0;
			comp_q  <= '0;
			msg_q   <= '0;
			chka_q  <= '0;
			chkb_q  <= '0;
			prev_q  <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			seq_q   <= seq_d;
			sys_q   <= sys_d;
			comp_q  <= comp_d;
			msg_q   <= msg_d;
			chka_q  <= chka_d;
			chkb_q  <= chkb_d;
			prev_q  <= prev_d;
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_d;
	end

	assign result.valid      = out_valid_q;
	assign result.out_kind   = res_q.out_kind;
	assign result.msg_id     = res_q.msg_id;
	assign result.seq_num    = res_q.seq_num;
	assign result.sys_id     = res_q.sys_id;
	assign result.comp_id    = res_q.comp_id;
	assign result.byte_index = res_q.byte_index;
	assign result.data_byte  = res_q.data_byte;
	assign result.check_a    = res_q.check_a;
	assign result.check_b    = res_q.check_b;
	assign result.status     = res_q.status;

	// Link loss always returns the parser to hunting
	a_lost_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && kind_s1 == IN_LINK_LOST |=> phase_q == PH_HUNT)
		else $error("parser not hunting after link loss");

	// Bytes seen while hunting never produce a result
	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && kind_s1 == IN_BYTE && phase_q == PH_HUNT |-> !res_load)
		else $error("result produced while hunting");

	// Header position stays within the five header fields
	a_head_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEAD |-> cnt_q <= HDR_LAST)
		else $error("header counter out of range");

	// A pending payload result indexes inside the current payload
	a_pay_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.out_kind == KIND_PAYLOAD |-> res_q.byte_index < len_q)
		else $error("payload index beyond payload length");

endmodule
`default_nettype wire

@@ tb/lfd_checker.sv @@
// Checker: watches the deframer channels, predicts every result and compares it field by field.
module lfd_checker
	import lfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lfd_in_if    rx,
	lfd_out_if   result,
	lfd_cfg_if   cfg,
	output int   fail_count,
	output int   due_count,
	output int   result_count,
	output int   status_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		P_HUNT,
		P_HEADER,
		P_PAYLOAD,
		P_CHECK_A,
		P_CHECK_B,
		P_END_BYTE
	} parse_phase_t;

	// Register copies
	byte_t sync_cfg = SYNC_BYTE_RST;
	byte_t end_cfg  = END_BYTE_RST;
	byte_t seq_cfg  = SEQ_MSG_RST;

	// Parser state
	parse_phase_t phase = P_HUNT;
	byte_t fld_cnt  = '0;
	byte_t pay_len  = '0;
	byte_t hdr_seq  = '0;
	byte_t hdr_sys  = '0;
	byte_t hdr_comp = '0;
	byte_t hdr_msg  = '0;
	byte_t chk_a    = '0;
	byte_t chk_b    = '0;
	byte_t prev_seq = '0;

	result_t results_due[$];
	int errors    = 0;
	int n_results = 0;
	int n_status  = 0;

	// Fill the header fields of a result from the current frame
	function automatic result_t tag_header(input logic k);
		result_t r;
		r = '0;
		r.out_kind = k;
		r.msg_id   = hdr_msg;
		r.seq_num  = hdr_seq;
		r.sys_id   = hdr_sys;
		r.comp_id  = hdr_comp;
		return r;
	endfunction

	// Advance the parser by one transfer; return 1 when it yields a result
	function automatic bit deframe_byte(input logic k, input byte_t b, output result_t r);
		bit      hit;
		status_t st;
		hit = 1'b0;
		r   = '0;
		if (k == IN_LINK_LOST) begin
			phase    = P_HUNT;
			fld_cnt  = '0;
			r.out_kind = KIND_STATUS;
			r.status   = ST_LINK_LOST;
			hit = 1'b1;
		end else begin
			case (phase)
			P_HEADER: begin
				case (fld_cnt)
				8'd0:    pay_len  = b;
				8'd1:    hdr_seq  = b;
				8'd2:    hdr_sys  = b;
				8'd3:    hdr_comp = b;
				default: hdr_msg  = b;
				endcase
				if (fld_cnt >= HDR_LAST) begin
					fld_cnt = '0;
					phase   = (pay_len == 8'd0) ? P_CHECK_A : P_PAYLOAD;
				end else begin
					fld_cnt = fld_cnt + 8'd1;
				end
			end
			P_PAYLOAD: begin
				r = tag_header(KIND_PAYLOAD);
				r.byte_index = fld_cnt;
				r.data_byte  = b;
				hit = 1'b1;
				fld_cnt = fld_cnt + 8'd1;
				if (fld_cnt >= pay_len) begin
					fld_cnt = '0;
					phase   = P_CHECK_A;
				end
			end
			P_CHECK_A: begin
				chk_a = b;
				phase = P_CHECK_B;
			end
			P_CHECK_B: begin
				chk_b = b;
				phase = P_END_BYTE;
			end
			P_END_BYTE: begin
				// gap check only for the sequenced id, and only on a good end byte
				if (b != end_cfg) begin
					st = ST_BAD_END;
				end else begin
					st = ST_OK;
					if (hdr_msg == seq_cfg) begin
						if (byte_t'(prev_seq + 8'd1) != hdr_seq)
							st = ST_SEQ_GAP;
						prev_seq = hdr_seq;
					end
				end
				r = tag_header(KIND_STATUS);
				r.check_a = chk_a;
				r.check_b = chk_b;
				r.status  = st;
				hit = 1'b1;
				phase   = P_HUNT;
				fld_cnt = '0;
			end
			default: begin
				if (b == sync_cfg) begin
					phase   = P_HEADER;
					fld_cnt = '0;
				end else begin
					phase = P_HUNT;
				end
			end
			endcase
		end
		return hit;
	endfunction

	function automatic int field_miss(input string name, input int unsigned want,
		input int unsigned got);
		if (want == got)
			return 0;
		$display("%0t: result field %s mismatch, expected 0x%0h, actual 0x%0h",
			$time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t pred;
		int      miss;
		if (!arst_n) begin
			sync_cfg = SYNC_BYTE_RST;
			end_cfg  = END_BYTE_RST;
			seq_cfg  = SEQ_MSG_RST;
			phase    = P_HUNT;
			fld_cnt  = '0;
			pay_len  = '0;
			hdr_seq  = '0;
			hdr_sys  = '0;
			hdr_comp = '0;
			hdr_msg  = '0;
			chk_a    = '0;
			chk_b    = '0;
			prev_seq = '0;
			results_due.delete();
			due_count <= 0;
		end else begin
			// update register copies on a config transfer
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_SYNC_BYTE: sync_cfg = cfg.data;
				CFG_END_BYTE:  end_cfg  = cfg.data;
				CFG_SEQ_MSG:   seq_cfg  = cfg.data;
				default: ;
				endcase
			end

			// compare a result transfer with the oldest prediction
			if (result.valid && result.ready) begin
				n_results++;
				if (result.out_kind == KIND_STATUS)
					n_status++;
				if (results_due.size() == 0) begin
					$display("%0t: result with nothing predicted, expected none, actual kind %0d status %0d",
						$time, result.out_kind, result.status);
					errors++;
				end else begin
					want = results_due.pop_front();
					miss = field_miss("out_kind", want.out_kind, result.out_kind)
						+ field_miss("msg_id", want.msg_id, result.msg_id)
						+ field_miss("seq_num", want.seq_num, result.seq_num)
						+ field_miss("sys_id", want.sys_id, result.sys_id)
						+ field_miss("comp_id", want.comp_id, result.comp_id)
						+ field_miss("byte_index", want.byte_index, result.byte_index)
						+ field_miss("data_byte", want.data_byte, result.data_byte)
						+ field_miss("check_a", want.check_a, result.check_a)
						+ field_miss("check_b", want.check_b, result.check_b)
						+ field_miss("status", want.status, result.status);
					if (miss != 0)
						errors++;
				end
			end

			// predict from an input transfer
			if (rx.valid && rx.ready) begin
				if (deframe_byte(rx.kind, rx.rx_byte, pred))
					results_due.push_back(pred);
			end
			due_count <= results_due.size();
		end
		fail_count   <= errors;
		result_count <= n_results;
		status_count <= n_status;
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: drives frames, noise and link-lost events into the deframer and gives the verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lfd_pkg::*;

	localparam cfg_idx_t CFG_SPARE  = 2'd3;
	localparam int RANDOM_ITEMS     = 450;
	localparam int RANDOM_PHASES    = 5;
	localparam int LONG_FRAME_ITEMS = 255 + 9;
	localparam int SETTLE_CYCLES    = 4;
	localparam int LONG_HOLD        = 150;
	localparam int PRESSURE_ITEMS   = 40;
	localparam int TIMEOUT_NS       = 6_000_000;

	typedef struct packed {
		logic  kind;
		byte_t data;
	} rx_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lfd_in_if  rx_ch ();
	lfd_out_if res_ch ();
	lfd_cfg_if cfg_ch ();

	int fail_count;
	int due_count;
	int result_count;
	int status_count;

	link_frame_deframer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.rx     (rx_ch),
		.result (res_ch)
	);

	lfd_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx_ch),
		.result       (res_ch),
		.cfg          (cfg_ch),
		.fail_count   (fail_count),
		.due_count    (due_count),
		.result_count (result_count),
		.status_count (status_count)
	);

	rx_item_t tx_q[$];
	byte_t    sync_val    = SYNC_BYTE_RST;
	byte_t    end_val     = END_BYTE_RST;
	byte_t    seq_msg_val = SEQ_MSG_RST;
	byte_t    next_seq    = 8'd1;
	bit       calm        = 1'b0;
	bit       hold_req    = 1'b0;
	int       burst_left  = 0;
	int       sent        = 0;
	int       cfg_writes  = 0;
	int       settings_used = 1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout, %0d results still due", $time, due_count);
		$display("link_frame_deframer regression: fail");
		$finish;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_rx(input logic k, input byte_t b);
		rx_item_t it;
		it.kind = k;
		it.data = b;
		tx_q.push_back(it);
	endfunction

	// Queue one whole frame; extreme_data alternates 0x00 and 0xFF in the body
	function automatic void push_frame(input byte_t len, input byte_t seq, input byte_t sys,
		input byte_t comp, input byte_t msg, input bit good_end, input bit extreme_data);
		push_rx(IN_BYTE, sync_val);
		push_rx(IN_BYTE, len);
		push_rx(IN_BYTE, seq);
		push_rx(IN_BYTE, sys);
		push_rx(IN_BYTE, comp);
		push_rx(IN_BYTE, msg);
		for (int i = 0; i < len; i++)
			push_rx(IN_BYTE, extreme_data ? ((i % 2) ? 8'hFF : 8'h00) : byte_t'($urandom));
		push_rx(IN_BYTE, extreme_data ? 8'h00 : byte_t'($urandom));
		push_rx(IN_BYTE, extreme_data ? 8'hFF : byte_t'($urandom));
		push_rx(IN_BYTE, good_end ? end_val : byte_t'(end_val ^ byte_t'($urandom_range(1, 255))));
		if (good_end && msg == seq_msg_val)
			next_seq = byte_t'(seq + 8'd1);
	endfunction

	// Queue one random scenario; return how many items count toward the quota
	function automatic int build_scenario();
		int    r;
		int    n;
		byte_t len;
		byte_t msg;
		byte_t seq;
		byte_t b;
		r    = $urandom_range(0, 99);
		calm = ($urandom_range(0, 9) == 0);
		len  = ($urandom_range(0, 9) < 4) ? byte_t'($urandom_range(0, 2))
			: byte_t'($urandom_range(3, 12));
		msg  = $urandom_range(0, 1) ? seq_msg_val : byte_t'($urandom);
		seq  = ($urandom_range(0, 3) != 0) ? next_seq : byte_t'($urandom);
		if (r < 62) begin
			// well-formed frame, mostly with a good end byte
			push_frame(len, seq, byte_t'($urandom), byte_t'($urandom), msg,
				$urandom_range(0, 9) != 0, 1'b0);
			return len + 9;
		end
		if (r < 74) begin
			// frame cut short by a link-lost event
			n = $urandom_range(1, 10);
			push_rx(IN_BYTE, sync_val);
			for (int i = 0; i < n; i++)
				push_rx(IN_BYTE, byte_t'($urandom));
			push_rx(IN_LINK_LOST, byte_t'($urandom));
			return n + 2;
		end
		if (r < 84) begin
			// line noise while hunting
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				b = byte_t'($urandom);
				if (b == sync_val)
					b = b ^ 8'h01;
				push_rx(IN_BYTE, b);
			end
			return n;
		end
		if (r < 90) begin
			push_rx(IN_LINK_LOST, byte_t'($urandom));
			return 1;
		end
		// sequenced frame with a bad end byte: previous sequence must hold
		push_frame(len, seq, byte_t'($urandom), byte_t'($urandom), seq_msg_val, 1'b0, 1'b0);
		return len + 9;
	endfunction

	task automatic send_item(input rx_item_t it);
		int gap;
		gap = (calm || burst_left > 0) ? 0 : pick_gap();
		if (burst_left > 0)
			burst_left--;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.kind    <= it.kind;
		rx_ch.rx_byte <= it.data;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_queued();
		while (tx_q.size() > 0)
			send_item(tx_q.pop_front());
	endtask

	// Drop valid, wait for every predicted result, then let the pipeline settle
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input byte_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_writes++;
	endtask

	task automatic apply_settings(input byte_t s, input byte_t e, input byte_t m,
		input bit touch_spare);
		if (touch_spare)
			cfg_write(CFG_SPARE, byte_t'($urandom));
		cfg_write(CFG_SYNC_BYTE, s);
		cfg_write(CFG_END_BYTE, e);
		cfg_write(CFG_SEQ_MSG, m);
		cfg_ch.valid <= 1'b0;
		sync_val    = s;
		end_val     = e;
		seq_msg_val = m;
		settings_used++;
	endtask

	task automatic run_random(input int quota);
		int counted;
		counted = 0;
		while (counted < quota) begin
			counted += build_scenario();
			send_queued();
		end
	endtask

	// Result ready: random stalls, calm stretches, and one long hold on request
	initial begin : result_ready_drive
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left   = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (calm || run_left > 0) begin
				res_ch.ready <= 1'b1;
				if (run_left > 0)
					run_left--;
			end else begin
				stall_left = pick_gap();
				run_left   = $urandom_range(1, 24);
				if (stall_left > 0) begin
					res_ch.ready <= 1'b0;
					stall_left--;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	initial begin : stimulus
		rx_ch.valid    <= 1'b0;
		rx_ch.kind     <= IN_BYTE;
		rx_ch.rx_byte  <= 8'h00;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= CFG_SYNC_BYTE;
		cfg_ch.data    <= 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: noise, idle link loss, ok, gap, bad end, loss inside a header
		push_rx(IN_BYTE, 8'h00);
		push_rx(IN_LINK_LOST, 8'hFF);
		push_frame(8'd0, 8'd1, 8'hFF, 8'h00, seq_msg_val, 1'b1, 1'b1);
		push_frame(8'd2, 8'hFF, 8'h00, 8'hFF, seq_msg_val, 1'b1, 1'b1);
		push_frame(8'd0, 8'h00, 8'h12, 8'h34, 8'hFF, 1'b0, 1'b0);
		push_rx(IN_BYTE, sync_val);
		push_rx(IN_BYTE, 8'd3);
		push_rx(IN_LINK_LOST, 8'h00);
		send_queued();
		drain();

		// Random phases; phases 1 to 3 apply new register settings, phase 4 restores the reset values
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
			1: apply_settings(8'h00, 8'hFF, 8'h00, 1'b1);
			2: apply_settings(8'hFF, 8'h00, 8'hFF, 1'b0);
			3: apply_settings(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), 1'b0);
			4: apply_settings(SYNC_BYTE_RST, END_BYTE_RST, SEQ_MSG_RST, 1'b0);
			default: ;
			endcase
			if (ph == 2) begin
				// hold the result side off while the sender keeps pushing
				hold_req   = 1'b1;
				burst_left = PRESSURE_ITEMS;
			end
			if (ph == 3) begin
				// one frame with the longest payload
				calm = 1'b0;
				push_frame(8'd255, next_seq, byte_t'($urandom), byte_t'($urandom),
					seq_msg_val, 1'b1, 1'b0);
				send_queued();
			end
			run_random((RANDOM_ITEMS - LONG_FRAME_ITEMS) / RANDOM_PHASES);
			drain();
		end

		$display("Covered %0d input transfers and %0d register writes over %0d settings.",
			sent, cfg_writes, settings_used);
		$display("Checked %0d results, %0d of them frame or link status.",
			result_count, status_count);
		if (fail_count == 0 && due_count == 0) begin
			$display("link_frame_deframer regression: pass");
		end else begin
			$display("link_frame_deframer regression: fail");
		end
		$finish;
	end

endmodule
